### src/mrp_pkg.sv
// ============================================================================
// mrp_pkg
// Shared widths, codes and controller/datapath interface types for the
// message rate policer.
// ============================================================================
package mrp_pkg;

    // per-second history ring depth
    localparam int WINDOW_DEPTH = 64;
    localparam int POS_W        = $clog2(WINDOW_DEPTH);
    localparam int LEN_W        = $clog2(WINDOW_DEPTH + 1);

    // field widths
    localparam int TICK_W = 32;
    localparam int LVL_W  = 31;
    localparam int VTL_W  = 8;
    localparam int WLEN_W = 7;
    localparam int CFG_W  = 31;

    // window sum can grow to depth * 2^32
    localparam int ACC_W = TICK_W + LEN_W;

    // rate divider: count * 1000 fits in 32 + 10 bits
    localparam int MS_W   = 10;
    localparam int DIVD_W = TICK_W + MS_W;
    localparam int DCNT_W = $clog2(DIVD_W);

    // whole seconds: floor(t / 1000) = (t * RECIP_1000) >> RECIP_SHIFT, exact on 32 bits
    localparam int              SECS_W      = 23;
    localparam int              RECIP_SHIFT = 38;
    localparam logic [31:0]     RECIP_1000  = 32'h10624DD3;
    localparam logic [TICK_W-1:0] MS_PER_SEC = 32'd1000;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WARN_LEVEL       = 3'd0,
        REG_ALARM_LEVEL      = 3'd1,
        REG_DISCONNECT_LEVEL = 3'd2,
        REG_CUMULATIVE_LIMIT = 3'd3,
        REG_VIOLATIONS_LOCK  = 3'd4,
        REG_WINDOW_LEN       = 3'd5
    } cfg_index_t;

    // result codes
    localparam logic [1:0] LEVEL_NORMAL = 2'd0;
    localparam logic [1:0] LEVEL_WARN   = 2'd1;
    localparam logic [1:0] LEVEL_ALARM  = 2'd2;
    localparam logic [1:0] GRADE_DISC   = 2'd3;

    localparam logic [1:0] VIOL_NONE  = 2'd0;
    localparam logic [1:0] VIOL_RATE  = 2'd1;
    localparam logic [1:0] VIOL_BURST = 2'd2;
    localparam logic [1:0] VIOL_CUM   = 2'd3;

    typedef struct packed {
        logic [LVL_W-1:0]  warn_level;
        logic [LVL_W-1:0]  alarm_level;
        logic [LVL_W-1:0]  disconnect_level;
        logic [LVL_W-1:0]  cumulative_limit;
        logic [VTL_W-1:0]  violations_to_lock;
        logic [WLEN_W-1:0] window_len;
    } mrp_cfg_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic restart;
        logic eval;
        logic div_step;
        logic setup;
        logic fill;
        logic put;
        logic grade;
        logic sum_step;
        logic cum;
        logic finish;
        logic out_load;
    } mrp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_restart;
        logic win_due;
        logic div_last;
        logic fill_done;
        logic grade_viol;
        logic sum_done;
        logic out_free;
    } mrp_status_t;

endpackage

### src/message_rate_policer.sv
// ============================================================================
// message_rate_policer
// Message rate policer top level: configuration registers, sequencer and
// datapath.
// ============================================================================
// One word is processed at a time and each word returns one result word.
// A message inside the current one-second window reads the history RAM
// one slot a cycle for the window sum, len being the effective window
// length; a burst violation skips the sum. A message that closes a window
// adds the serial rate divider, setup, fill check and ring write, and
// marks each idle second (at most len) empty in the ring. A finished result
// waits in the output register while the next word is accepted. The history
// ring clears through per-slot valid bits, so no clearing pass follows reset
// or restart.
module message_rate_policer import mrp_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    // input words
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_req_type,
    input  logic [TICK_W-1:0]    s_now_ms,
    // result words
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_warning_level,
    output logic [1:0]           m_violation,
    output logic                 m_lock_session,
    output logic [TICK_W-1:0]    m_rate_per_sec,
    output logic [TICK_W-1:0]    m_window_sum
);

    mrp_cfg_t    cfg_reg;
    mrp_cmd_t    cmd;
    mrp_status_t status;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.warn_level         <= LVL_W'(80);
            cfg_reg.alarm_level        <= LVL_W'(90);
            cfg_reg.disconnect_level   <= LVL_W'(100);
            cfg_reg.cumulative_limit   <= LVL_W'(6000);
            cfg_reg.violations_to_lock <= VTL_W'(3);
            cfg_reg.window_len         <= WLEN_W'(60);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_WARN_LEVEL:       cfg_reg.warn_level         <= cfg_wdata[LVL_W-1:0];
                REG_ALARM_LEVEL:      cfg_reg.alarm_level        <= cfg_wdata[LVL_W-1:0];
                REG_DISCONNECT_LEVEL: cfg_reg.disconnect_level   <= cfg_wdata[LVL_W-1:0];
                REG_CUMULATIVE_LIMIT: cfg_reg.cumulative_limit   <= cfg_wdata[LVL_W-1:0];
                REG_VIOLATIONS_LOCK:  cfg_reg.violations_to_lock <= cfg_wdata[VTL_W-1:0];
                REG_WINDOW_LEN:       cfg_reg.window_len         <= cfg_wdata[WLEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    mrp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    mrp_dpath u_dpath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .cmd             (cmd),
        .status          (status),
        .s_req_type      (s_req_type),
        .s_now_ms        (s_now_ms),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_warning_level (m_warning_level),
        .m_violation     (m_violation),
        .m_lock_session  (m_lock_session),
        .m_rate_per_sec  (m_rate_per_sec),
        .m_window_sum    (m_window_sum)
    );

    // one word in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("word accepted while previous word still in work");

    // rate or burst violations carry no window sum
    a_viol_sum_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && ((m_violation == VIOL_RATE) || (m_violation == VIOL_BURST)))
            |-> (m_window_sum == '0))
        else $error("window sum reported with rate or burst violation");

    // lock only comes with a violation
    a_lock_needs_viol: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_lock_session) |-> (m_violation != VIOL_NONE))
        else $error("session lock without violation");

    // a violation clears the warning grade
    a_viol_level_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_violation != VIOL_NONE)) |-> (m_warning_level == LEVEL_NORMAL))
        else $error("warning level set alongside a violation");

endmodule

### src/mrp_ram.sv
// ============================================================================
// mrp_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module mrp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/mrp_ctrl.sv
// ============================================================================
// mrp_ctrl
// Sequencer for the policer: steps the datapath through evaluation or restart,
// rate divide, idle-second fill, ring write, grading, ring sum and result hand-off.
// ============================================================================
module mrp_ctrl import mrp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  mrp_status_t status,
    output mrp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_SETUP,
        ST_FILL,
        ST_PUT,
        ST_GRADE,
        ST_SUM,
        ST_CUM,
        ST_FIN,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg;

    assign s_ready = ready_reg;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && ready_reg) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (status.is_restart) begin
                    cmd.restart = 1'b1;
                    state_next  = ST_DONE;
                end else begin
                    cmd.eval   = 1'b1;
                    state_next = status.win_due ? ST_DIV : ST_GRADE;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                cmd.setup  = 1'b1;
                state_next = ST_FILL;
            end
            ST_FILL: begin
                if (status.fill_done) begin
                    state_next = ST_PUT;
                end else begin
                    cmd.fill = 1'b1;
                end
            end
            ST_PUT: begin
                cmd.put    = 1'b1;
                state_next = ST_GRADE;
            end
            ST_GRADE: begin
                cmd.grade  = 1'b1;
                state_next = status.grade_viol ? ST_FIN : ST_SUM;
            end
            ST_SUM: begin
                cmd.sum_step = 1'b1;
                if (status.sum_done) begin
                    state_next = ST_CUM;
                end
            end
            ST_CUM: begin
                cmd.cum    = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                cmd.finish = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered ready
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ready_reg <= (state_next == ST_IDLE);
        end
    end

endmodule

### src/mrp_dpath.sv
// ============================================================================
// mrp_dpath
// Policer datapath: window state, serial rate divider, history ring with
// valid bits, serial ring sum, grading, violation counter and result register.
// ============================================================================
module mrp_dpath import mrp_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  mrp_cfg_t          cfg,
    input  mrp_cmd_t          cmd,
    output mrp_status_t       status,
    input  logic              s_req_type,
    input  logic [TICK_W-1:0] s_now_ms,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_warning_level,
    output logic [1:0]        m_violation,
    output logic              m_lock_session,
    output logic [TICK_W-1:0] m_rate_per_sec,
    output logic [TICK_W-1:0] m_window_sum
);

    // captured word
    logic              req_reg;
    logic [TICK_W-1:0] now_reg;

    // persistent policer state
    logic [TICK_W-1:0]       window_start_reg;
    logic [TICK_W-1:0]       pending_reg;
    logic [TICK_W-1:0]       last_rate_reg;
    logic [POS_W-1:0]        pos_reg;
    logic [WINDOW_DEPTH-1:0] valid_reg;
    logic [VTL_W-1:0]        viol_cnt_reg;

    // per-word working registers
    logic              win_reg;
    logic [DIVD_W-1:0] dq_reg;
    logic [TICK_W:0]   rem_reg;
    logic [TICK_W-1:0] divisor_reg;
    logic [DCNT_W-1:0] div_cnt_reg;
    logic [SECS_W-1:0] secs_reg;
    logic [LEN_W-1:0]  idle_reg;
    logic [1:0]        level_reg;
    logic [1:0]        viol_reg;
    logic              lock_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [LEN_W-1:0]  idx_reg;
    logic              rd_pend_reg;
    logic              rd_bit_reg;
    logic              m_valid_reg;

    logic [TICK_W-1:0] ram_rdata;

    // effective window length: zero acts as one, capped at the ring depth
    logic [LEN_W-1:0] len;
    always_comb begin
        if (cfg.window_len == '0) begin
            len = LEN_W'(1);
        end else if (32'(cfg.window_len) > 32'(WINDOW_DEPTH)) begin
            len = LEN_W'(WINDOW_DEPTH);
        end else begin
            len = LEN_W'(cfg.window_len);
        end
    end

    // window timing
    logic [TICK_W-1:0] elapsed;
    logic              win_due;
    logic [TICK_W-1:0] pending_inc;
    logic [63:0]       secs_prod;
    logic [SECS_W-1:0] secs_next;

    assign elapsed     = now_reg - window_start_reg;
    assign win_due     = (elapsed >= MS_PER_SEC);
    assign pending_inc = (pending_reg == '1) ? pending_reg : pending_reg + TICK_W'(1);
    assign secs_prod   = 64'(elapsed) * 64'(RECIP_1000);
    assign secs_next   = secs_prod[RECIP_SHIFT +: SECS_W];

    // ring position, restarted when it lies past the window length
    logic [POS_W-1:0] pos_cur;
    logic [LEN_W-1:0] pos_inc;
    logic [POS_W-1:0] pos_adv;

    assign pos_cur = (LEN_W'(pos_reg) >= len) ? '0 : pos_reg;
    assign pos_inc = LEN_W'(pos_cur) + LEN_W'(1);
    assign pos_adv = (pos_inc >= len) ? '0 : pos_inc[POS_W-1:0];

    // restoring divider step, one quotient bit a cycle
    logic [TICK_W:0]   rem_shift;
    logic              rem_fits;
    logic [TICK_W:0]   rem_new;
    logic [DIVD_W-1:0] dq_new;
    logic [TICK_W-1:0] rate_q;

    assign rem_shift = {rem_reg[TICK_W-1:0], dq_reg[DIVD_W-1]};
    assign rem_fits  = (rem_shift >= {1'b0, divisor_reg});
    assign rem_new   = rem_fits ? (rem_shift - {1'b0, divisor_reg}) : rem_shift;
    assign dq_new    = {dq_reg[DIVD_W-2:0], rem_fits};
    assign rate_q    = (|dq_reg[DIVD_W-1:TICK_W]) ? '1 : dq_reg[TICK_W-1:0];

    // idle seconds minus the current one, capped at the window length
    logic [SECS_W-1:0] secs_m1;
    logic [LEN_W-1:0]  idle_next;

    assign secs_m1   = secs_reg - SECS_W'(1);
    assign idle_next = (secs_m1 > SECS_W'(len)) ? len : LEN_W'(secs_m1);

    // grading of the rate or the running count
    function automatic logic [1:0] grade_of(input logic [TICK_W-1:0] v, input mrp_cfg_t c);
        logic [1:0] g;
        if (v < TICK_W'(c.warn_level)) begin
            g = LEVEL_NORMAL;
        end else if (v < TICK_W'(c.alarm_level)) begin
            g = LEVEL_WARN;
        end else if (v < TICK_W'(c.disconnect_level)) begin
            g = LEVEL_ALARM;
        end else begin
            g = GRADE_DISC;
        end
        return g;
    endfunction

    logic [TICK_W-1:0] grade_val;
    logic [1:0]        grade_cur;

    assign grade_val = win_reg ? last_rate_reg : pending_reg;
    assign grade_cur = grade_of(grade_val, cfg);

    // violation counter step
    logic [VTL_W-1:0] viol_cnt_inc;
    logic             lock_hit;

    assign viol_cnt_inc = viol_cnt_reg + VTL_W'(1);
    assign lock_hit     = (viol_cnt_inc >= cfg.violations_to_lock);

    // history ring storage
    mrp_ram #(
        .WIDTH (TICK_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_hist (
        .aclk  (aclk),
        .we    (cmd.put),
        .waddr (pos_cur),
        .wdata (last_rate_reg),
        .raddr (idx_reg[POS_W-1:0]),
        .rdata (ram_rdata)
    );

    // status to the controller
    assign status.is_restart = req_reg;
    assign status.win_due    = win_due;
    assign status.div_last   = (div_cnt_reg == DCNT_W'(DIVD_W - 1));
    assign status.fill_done  = (idle_reg == '0);
    assign status.grade_viol = (grade_cur == GRADE_DISC);
    assign status.sum_done   = (idx_reg >= len) && !rd_pend_reg;
    assign status.out_free   = !m_valid_reg || m_ready;

    // persistent state and handshake flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_start_reg <= '0;
            pending_reg      <= '0;
            last_rate_reg    <= '0;
            pos_reg          <= '0;
            valid_reg        <= '0;
            viol_cnt_reg     <= '0;
            rd_pend_reg      <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cmd.restart) begin
                valid_reg   <= '0;
                pos_reg     <= '0;
                pending_reg <= '0;
            end
            if (cmd.eval) begin
                pending_reg <= pending_inc;
            end
            if (cmd.setup) begin
                last_rate_reg    <= rate_q;
                window_start_reg <= now_reg;
                pending_reg      <= '0;
            end
            // idle second: slot reads back as zero
            if (cmd.fill) begin
                valid_reg[pos_cur] <= 1'b0;
                pos_reg            <= pos_adv;
            end
            if (cmd.put) begin
                valid_reg[pos_cur] <= 1'b1;
                pos_reg            <= pos_adv;
            end
            if (cmd.grade) begin
                rd_pend_reg <= 1'b0;
            end
            if (cmd.sum_step) begin
                rd_pend_reg <= (idx_reg < len);
            end
            if (cmd.finish && (viol_reg != VIOL_NONE)) begin
                viol_cnt_reg <= lock_hit ? '0 : viol_cnt_inc;
            end
            // result register
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg <= s_req_type;
            now_reg <= s_now_ms;
        end
        if (cmd.restart) begin
            level_reg <= LEVEL_NORMAL;
            viol_reg  <= VIOL_NONE;
            lock_reg  <= 1'b0;
            acc_reg   <= '0;
        end
        if (cmd.eval) begin
            win_reg     <= win_due;
            dq_reg      <= DIVD_W'(pending_inc) * DIVD_W'(MS_PER_SEC);
            rem_reg     <= '0;
            divisor_reg <= elapsed;
            div_cnt_reg <= '0;
            secs_reg    <= secs_next;
            lock_reg    <= 1'b0;
        end
        if (cmd.div_step) begin
            dq_reg      <= dq_new;
            rem_reg     <= rem_new;
            div_cnt_reg <= div_cnt_reg + DCNT_W'(1);
        end
        if (cmd.setup) begin
            idle_reg <= idle_next;
        end
        if (cmd.fill) begin
            idle_reg <= idle_reg - LEN_W'(1);
        end
        if (cmd.grade) begin
            acc_reg <= '0;
            idx_reg <= '0;
            if (grade_cur == GRADE_DISC) begin
                level_reg <= LEVEL_NORMAL;
                viol_reg  <= win_reg ? VIOL_RATE : VIOL_BURST;
            end else begin
                level_reg <= grade_cur;
                viol_reg  <= VIOL_NONE;
            end
        end
        // ring sum: the data for an address comes back in the next cycle
        if (cmd.sum_step) begin
            if (idx_reg < len) begin
                rd_bit_reg <= valid_reg[idx_reg[POS_W-1:0]];
                idx_reg    <= idx_reg + LEN_W'(1);
            end
            if (rd_pend_reg && rd_bit_reg) begin
                acc_reg <= acc_reg + ACC_W'(ram_rdata);
            end
        end
        if (cmd.cum && (acc_reg >= ACC_W'(cfg.cumulative_limit))) begin
            viol_reg  <= VIOL_CUM;
            level_reg <= LEVEL_NORMAL;
        end
        if (cmd.finish && (viol_reg != VIOL_NONE)) begin
            level_reg <= LEVEL_NORMAL;
            lock_reg  <= lock_hit;
        end
        if (cmd.out_load) begin
            m_warning_level <= level_reg;
            m_violation     <= viol_reg;
            m_lock_session  <= lock_reg;
            m_rate_per_sec  <= last_rate_reg;
            if ((viol_reg == VIOL_RATE) || (viol_reg == VIOL_BURST)) begin
                m_window_sum <= '0;
            end else if (|acc_reg[ACC_W-1:TICK_W]) begin
                m_window_sum <= '1;
            end else begin
                m_window_sum <= acc_reg[TICK_W-1:0];
            end
        end
    end

    assign m_valid = m_valid_reg;

endmodule
